[rtl/cws_pkg.sv]
// shared types, sizes and codes for the cumulative weight sampler
// no dependencies; imported by every module of the block
package cws_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SUM_W       = 32;
    localparam int VALUE_BITS  = 16;
    localparam int BIN_W       = 10;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    // item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } eng_state_t;

    // one result transaction
    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic [1:0]       status;
    } result_t;

    // bound memory access for one cycle
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [SUM_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

[rtl/cws_bound_mem.sv]
// single-port-write, single-port-read memory for the cumulative bounds
// depends on cws_pkg; read data is registered
module cws_bound_mem
    import cws_pkg::*;
(
    input  logic             aclk,
    input  mem_req_t         req,
    output logic [SUM_W-1:0] rd_data
);

    logic [SUM_W-1:0] mem [MAX_ENTRIES];
    logic [SUM_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/cws_engine.sv]
// table control: clear, append with saturating total, binary search sampler
// depends on cws_pkg; drives the bound memory through a mem_req_t
module cws_engine
    import cws_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [VALUE_BITS-1:0] s_weight,
    input  logic [VALUE_BITS-1:0] s_sample_point,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res,
    output mem_req_t              mem_req,
    input  logic [SUM_W-1:0]      mem_rd_data
);

    eng_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SUM_W-1:0]       total_reg, total_next;
    logic [ADDR_W-1:0]      lo_reg, lo_next;
    logic [ADDR_W-1:0]      hi_reg, hi_next;
    logic [ADDR_W-1:0]      mid_reg, mid_next;
    logic [VALUE_BITS-1:0]  r_reg, r_next;
    result_t                res_reg, res_next;

    logic                   accept;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;
    logic [ADDR_W-1:0]      hi_first;
    logic [ADDR_W-1:0]      step_lo;
    logic [ADDR_W-1:0]      step_hi;
    logic [ADDR_W-1:0]      step_mid;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // saturating running total
    assign sum_wide = {1'b0, total_reg} + (SUM_W + 1)'(s_weight);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    // top index of the table at the start of a search
    assign hi_first = ADDR_W'(count_reg - CNT_W'(1));

    // one search step on the bound read last cycle
    always_comb begin
        step_lo = lo_reg;
        step_hi = hi_reg;
        if (SUM_W'(r_reg) < mem_rd_data) begin
            step_hi = mid_reg;
        end else begin
            step_lo = mid_reg + ADDR_W'(1);
        end
        step_mid = step_lo + ((step_hi - step_lo) >> 1);
    end

    // state and table registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // search and result payload
    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        r_reg   <= r_next;
        res_reg <= res_next;
    end

    // next state, memory requests and results
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        total_next = total_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        r_next     = r_reg;
        res_next   = res_reg;
        mem_req    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next.bin_index = '0;
                    res_next.status    = STATUS_OK;
                    state_next         = ST_DONE;
                    case (s_kind)
                        KIND_CLEAR: begin
                            count_next = '0;
                            total_next = '0;
                        end
                        KIND_APPEND: begin
                            if (count_reg >= MAX_COUNT) begin
                                res_next.status    = STATUS_FULL;
                                res_next.bin_index = BIN_W'(count_reg - CNT_W'(1));
                            end else begin
                                total_next         = sum_sat;
                                mem_req.wr_en      = 1'b1;
                                mem_req.wr_addr    = ADDR_W'(count_reg);
                                mem_req.wr_data    = sum_sat;
                                count_next         = count_reg + CNT_W'(1);
                                res_next.bin_index = BIN_W'(count_reg);
                            end
                        end
                        KIND_SAMPLE: begin
                            if (count_reg == '0) begin
                                res_next.status = STATUS_EMPTY;
                            end else if (hi_first != '0) begin
                                // first probe at the middle of the table
                                lo_next         = '0;
                                hi_next         = hi_first;
                                mid_next        = hi_first >> 1;
                                r_next          = s_sample_point;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = hi_first >> 1;
                                state_next      = ST_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (step_lo < step_hi) begin
                    mid_next        = step_mid;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = step_mid;
                end else begin
                    res_next.bin_index = BIN_W'(step_lo);
                    res_next.status    = STATUS_OK;
                    state_next         = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // search window stays open while a probe is outstanding
    a_window_open: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> lo_reg < hi_reg)
        else $error("search window empty while searching");

    // probe lies inside the window
    a_mid_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> (mid_reg >= lo_reg) && (mid_reg < hi_reg))
        else $error("probe index outside search window");

    // no table writes during a search
    a_no_write_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> !mem_req.wr_en)
        else $error("bound memory written during search");

    // successful append grows the table by one
    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_kind == KIND_APPEND && count_reg < MAX_COUNT
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("entry count did not advance on append");

endmodule

[rtl/cumulative_weight_sampler_top.sv]
// roulette-wheel sampler top level: engine, bound memory and output register
// depends on cws_pkg, cws_bound_mem and cws_engine
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_kind s_weight          | in
//          | s_sample_point                          |
//  result  | m_valid m_ready m_bin_index m_status    | out
//
// clear, append and sample on an empty or one-entry table: the result goes from the engine's
// done state into the output register; a sample makes ceil(log2(entry count)) dependent
// reads of the bound memory, one per cycle, before its result does the same.
// aresetn (synchronous) empties the table; the bound memory itself is not cleared.
// the output register holds a stalled result while the engine takes the next item.
module cumulative_weight_sampler_top
    import cws_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [VALUE_BITS-1:0] s_weight,
    input  logic [VALUE_BITS-1:0] s_sample_point,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BIN_W-1:0]      m_bin_index,
    output logic [1:0]            m_status
);

    mem_req_t         mem_req;
    logic [SUM_W-1:0] mem_rd_data;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    logic             m_valid_reg, m_valid_next;
    result_t          m_res_reg, m_res_next;

    cws_bound_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    cws_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_weight       (s_weight),
        .s_sample_point (s_sample_point),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .mem_req        (mem_req),
        .mem_rd_data    (mem_rd_data)
    );

    // output register loads when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_index = m_res_reg.bin_index;
    assign m_status    = m_res_reg.status;

endmodule
